// File: rtl/dtc_pkg.sv
package dtc_pkg;

  localparam int NODES_DEF        = 256;
  localparam int ATTRS_DEF        = 16;
  localparam int CHILD_SLOTS_DEF  = 1024;
  localparam int MAX_CHILDREN_DEF = 16;

  localparam int OPCODE_W     = 2;
  localparam int NODE_IDX_W   = 8;
  localparam int SPLIT_W      = 4;
  localparam int VALUE_W      = 16;
  localparam int LABEL_W      = 16;
  localparam int BASE_W       = 10;
  localparam int COUNT_W      = 5;
  localparam int SLOT_IDX_W   = 10;
  localparam int ATTR_IDX_W   = 4;
  localparam int LEAF_NODE_W  = 8;
  localparam int IN_TDATA_W   = 104;
  localparam int OUT_TDATA_W  = 24;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WR_NODE,
    OP_WR_SLOT,
    OP_WR_ATTR,
    OP_CLASSIFY
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WBASE,
    ST_NODE,
    ST_SLOT,
    ST_CHILD,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    opcode_t                 opcode;
    logic [NODE_IDX_W-1:0]   node_index;
    logic                    is_leaf;
    logic [SPLIT_W-1:0]      split_attribute;
    logic [VALUE_W-1:0]      branch_value;
    logic [LABEL_W-1:0]      leaf_label;
    logic [BASE_W-1:0]       child_base;
    logic [COUNT_W-1:0]      child_count;
    logic [SLOT_IDX_W-1:0]   slot_index;
    logic [NODE_IDX_W-1:0]   slot_node;
    logic [ATTR_IDX_W-1:0]   attribute_index;
    logic [VALUE_W-1:0]      attribute_value;
  } req_t;

  typedef struct packed {
    logic [LABEL_W-1:0]     class_label;
    logic                   found;
    logic [LEAF_NODE_W-1:0] leaf_node;
  } result_t;

endpackage

// File: rtl/dtc_ram.sv
module dtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/dtc_base_mod.sv
module dtc_base_mod #(
  parameter int MODULUS = 1024,
  parameter int VAL_W   = 10,
  parameter int REM_W   = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [VAL_W-1:0] value,
  output logic             done,
  output logic [REM_W-1:0] rem
);

  localparam int RECIP = (1 << VAL_W) / MODULUS;
  localparam int PW    = 2 * VAL_W + 1;
  localparam int MW    = VAL_W + $clog2(MODULUS + 1);

  logic             quot_en_r, quot_en_nxt;
  logic             done_r, done_nxt;
  logic [VAL_W-1:0] acc_r, acc_nxt;
  logic [VAL_W-1:0] quot_r, quot_nxt;
  logic [PW-1:0]    prod;
  logic [MW-1:0]    back;
  logic [MW-1:0]    part;

  assign prod = PW'(acc_r) * PW'(RECIP);
  assign back = MW'(quot_r) * MW'(MODULUS);
  assign part = MW'(acc_r) - back;

  always_comb begin
    quot_en_nxt = start;
    done_nxt    = quot_en_r;
    acc_nxt     = start ? value : acc_r;
    quot_nxt    = quot_en_r ? VAL_W'(prod >> VAL_W) : quot_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quot_en_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      quot_en_r <= quot_en_nxt;
      done_r    <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    quot_r <= quot_nxt;
  end

  assign done = done_r;
  assign rem  = (part >= MW'(MODULUS)) ? REM_W'(part - MW'(MODULUS)) : REM_W'(part);

endmodule

// File: rtl/dtc_seq.sv
module dtc_seq
  import dtc_pkg::*;
#(
  parameter int NODES        = NODES_DEF,
  parameter int ATTRS        = ATTRS_DEF,
  parameter int CHILD_SLOTS  = CHILD_SLOTS_DEF,
  parameter int MAX_CHILDREN = MAX_CHILDREN_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    req_valid,
  output logic    req_ready,
  input  req_t    req,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  localparam int NW       = $clog2(NODES);
  localparam int SW       = $clog2(CHILD_SLOTS);
  localparam int AW       = (ATTRS > 1) ? $clog2(ATTRS) : 1;
  localparam int CLAMP    = (MAX_CHILDREN < 31) ? MAX_CHILDREN : 31;
  localparam int CW       = $clog2(CLAMP + 1);
  localparam int VW       = $clog2(NODES + 1);
  localparam int CNT_LO   = 0;
  localparam int BASE_LO  = CNT_LO + CW;
  localparam int LABEL_LO = BASE_LO + SW;
  localparam int BR_LO    = LABEL_LO + LABEL_W;
  localparam int SPL_LO   = BR_LO + VALUE_W;
  localparam int LEAF_BIT = SPL_LO + AW;
  localparam int EW       = LEAF_BIT + 1;
  localparam int SPL_TAB  = 1 << SPLIT_W;
  localparam int NODE_TAB = 1 << NODE_IDX_W;

  logic [AW-1:0] split_tab [SPL_TAB];
  logic [NW-1:0] node_tab  [NODE_TAB];

  for (genvar g = 0; g < SPL_TAB; g++) begin : g_split_tab
    assign split_tab[g] = AW'(g % ATTRS);
  end

  for (genvar g = 0; g < NODE_TAB; g++) begin : g_node_tab
    assign node_tab[g] = NW'(g % NODES);
  end

  seq_state_t state_r, state_nxt;
  logic [NW-1:0] cur_r, cur_nxt;
  logic [VW-1:0] visits_r, visits_nxt;
  logic [VALUE_W-1:0] want_r, want_nxt;
  logic [SW-1:0] slot_r, slot_nxt, slot_inc;
  logic [CW-1:0] left_r, left_nxt;
  logic [NW-1:0] nx_r, nx_nxt;
  result_t res_r, res_nxt;

  logic [NW-1:0]      wnode_r;
  logic               wleaf_r;
  logic [AW-1:0]      wsplit_r;
  logic [VALUE_W-1:0] wbranch_r;
  logic [LABEL_W-1:0] wlabel_r;
  logic [CW-1:0]      wcount_r;

  logic [VALUE_W-1:0] sample_r [ATTRS];

  logic          accept;
  logic          node_ok, slot_ok, attr_ok;
  logic          hold_wr;
  logic          node_we, slot_we, attr_we;
  logic [EW-1:0] node_wdata, node_rdata;
  logic [NW-1:0] node_raddr;
  logic [SW-1:0] slot_raddr;
  logic [NW-1:0] slot_rdata;
  logic          mod_start, mod_done;
  logic [SW-1:0] mod_rem;

  logic               nd_leaf;
  logic [AW-1:0]      nd_split;
  logic [VALUE_W-1:0] nd_branch;
  logic [LABEL_W-1:0] nd_label;
  logic [SW-1:0]      nd_base;
  logic [CW-1:0]      nd_count;

  assign nd_leaf   = node_rdata[LEAF_BIT];
  assign nd_split  = node_rdata[SPL_LO +: AW];
  assign nd_branch = node_rdata[BR_LO +: VALUE_W];
  assign nd_label  = node_rdata[LABEL_LO +: LABEL_W];
  assign nd_base   = node_rdata[BASE_LO +: SW];
  assign nd_count  = node_rdata[CNT_LO +: CW];

  assign req_ready = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_DONE);
  assign res       = res_r;
  assign accept    = req_valid && req_ready;

  assign node_ok = int'(req.node_index) < NODES;
  assign slot_ok = int'(req.slot_index) < CHILD_SLOTS;
  assign attr_ok = int'(req.attribute_index) < ATTRS;

  assign hold_wr   = accept && (req.opcode == OP_WR_NODE) && node_ok;
  assign mod_start = hold_wr;
  assign slot_we   = accept && (req.opcode == OP_WR_SLOT) && slot_ok;
  assign attr_we   = accept && (req.opcode == OP_WR_ATTR) && attr_ok;
  assign node_we   = (state_r == ST_WBASE) && mod_done;
  assign node_wdata = {wleaf_r, wsplit_r, wbranch_r, wlabel_r, mod_rem, wcount_r};

  assign slot_inc = (slot_r == SW'(CHILD_SLOTS - 1)) ? '0 : SW'(slot_r + 1'b1);

  dtc_base_mod #(
    .MODULUS (CHILD_SLOTS),
    .VAL_W   (BASE_W),
    .REM_W   (SW)
  ) u_base_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .value (req.child_base),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  dtc_ram #(
    .WIDTH (EW),
    .DEPTH (NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (wnode_r),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  dtc_ram #(
    .WIDTH (NW),
    .DEPTH (CHILD_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (SW'(req.slot_index)),
    .wdata (node_tab[req.slot_node]),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    visits_nxt = visits_r;
    want_nxt   = want_r;
    slot_nxt   = slot_r;
    left_nxt   = left_r;
    nx_nxt     = nx_r;
    res_nxt    = res_r;
    node_raddr = nx_r;
    slot_raddr = slot_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (req.opcode)
            OP_WR_NODE: begin
              if (node_ok) begin
                state_nxt = ST_WBASE;
              end
            end
            OP_CLASSIFY: begin
              cur_nxt    = '0;
              visits_nxt = '0;
              node_raddr = '0;
              state_nxt  = ST_NODE;
            end
            default: begin
            end
          endcase
        end
      end
      ST_WBASE: begin
        if (mod_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_NODE: begin
        visits_nxt = VW'(visits_r + 1'b1);
        if (nd_leaf) begin
          res_nxt   = '{class_label: nd_label, found: 1'b1,
                        leaf_node: LEAF_NODE_W'(cur_r)};
          state_nxt = ST_DONE;
        end else begin
          want_nxt   = sample_r[nd_split];
          slot_nxt   = nd_base;
          left_nxt   = nd_count;
          slot_raddr = nd_base;
          if (nd_count == '0) begin
            res_nxt   = '0;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SLOT;
          end
        end
      end
      ST_SLOT: begin
        nx_nxt     = slot_rdata;
        node_raddr = slot_rdata;
        state_nxt  = ST_CHILD;
      end
      ST_CHILD: begin
        if (nd_branch == want_r) begin
          cur_nxt    = nx_r;
          node_raddr = nx_r;
          if (visits_r == VW'(NODES)) begin
            res_nxt   = '0;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_NODE;
          end
        end else begin
          left_nxt   = left_r - 1'b1;
          slot_nxt   = slot_inc;
          slot_raddr = slot_inc;
          if (left_r == CW'(1)) begin
            res_nxt   = '0;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SLOT;
          end
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cur_r    <= '0;
      visits_r <= '0;
    end else begin
      state_r  <= state_nxt;
      cur_r    <= cur_nxt;
      visits_r <= visits_nxt;
    end
  end

  always_ff @(posedge clk) begin
    want_r <= want_nxt;
    slot_r <= slot_nxt;
    left_r <= left_nxt;
    nx_r   <= nx_nxt;
    res_r  <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (hold_wr) begin
      wnode_r   <= NW'(req.node_index);
      wleaf_r   <= req.is_leaf;
      wsplit_r  <= split_tab[req.split_attribute];
      wbranch_r <= req.branch_value;
      wlabel_r  <= req.leaf_label;
      wcount_r  <= (int'(req.child_count) > CLAMP) ? CW'(CLAMP) : CW'(req.child_count);
    end
  end

  always_ff @(posedge clk) begin
    if (attr_we) begin
      sample_r[AW'(req.attribute_index)] <= req.attribute_value;
    end
  end

  a_visit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    visits_r <= VW'(NODES))
    else $error("walk entered more nodes than the table holds");

  a_scan_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SLOT) |-> (left_r != '0))
    else $error("child scan running with no children left");

  a_child_after_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHILD) |-> ($past(state_r) == ST_SLOT))
    else $error("child compare without a slot fetch");

  a_node_write_ends: assert property (@(posedge clk) disable iff (!rst_n)
    node_we |=> (state_r == ST_IDLE))
    else $error("node write did not return to idle");

endmodule

// File: rtl/decision_tree_classifier_core.sv
// Categorical decision tree inference over on-chip tables. Requests on the input
// stream carry an opcode in in_tuser: node write, child slot write, sample
// attribute write, or classify; only classify returns a result. While a node
// write is in progress, the child base is reduced modulo CHILD_SLOTS by a
// reciprocal multiply and one correcting subtract. A classify reads each node
// it enters, then examines each child by a slot read followed by the child's
// branch read through the single node table read port, and finally hands the
// result to the output register. The output register frees the walk as soon
// as the result is loaded. Tables have no reset: classify only over entries
// that were written.
module decision_tree_classifier_core
  import dtc_pkg::*;
#(
  parameter int NODES        = NODES_DEF,
  parameter int ATTRS        = ATTRS_DEF,
  parameter int CHILD_SLOTS  = CHILD_SLOTS_DEF,
  parameter int MAX_CHILDREN = MAX_CHILDREN_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // node_index, is_leaf, split_attribute, branch_value, leaf_label, child_base,
  // child_count, slot_index, slot_node, attribute_index, attribute_value
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // opcode
  input  logic [OPCODE_W-1:0]    in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // class_label, leaf_node
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // found
  output logic                   out_tuser
);

  req_t    req;
  logic    res_valid, res_ready;
  result_t res;
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;

  assign req.opcode          = opcode_t'(in_tuser);
  assign req.node_index      = in_tdata[7:0];
  assign req.is_leaf         = in_tdata[8];
  assign req.split_attribute = in_tdata[12:9];
  assign req.branch_value    = in_tdata[28:13];
  assign req.leaf_label      = in_tdata[44:29];
  assign req.child_base      = in_tdata[54:45];
  assign req.child_count     = in_tdata[59:55];
  assign req.slot_index      = in_tdata[69:60];
  assign req.slot_node       = in_tdata[77:70];
  assign req.attribute_index = in_tdata[81:78];
  assign req.attribute_value = in_tdata[97:82];

  dtc_seq #(
    .NODES        (NODES),
    .ATTRS        (ATTRS),
    .CHILD_SLOTS  (CHILD_SLOTS),
    .MAX_CHILDREN (MAX_CHILDREN)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.leaf_node, out_res_r.class_label};
  assign out_tuser  = out_res_r.found;

endmodule
